// File: rtl/plir_pkg.sv
// Package for the pair list block: sizes, codes, pair and command types.
// Used by plir_cell, plir_chain and pair_list_insert_remove_range_top.
package plir_pkg;

    localparam int CAPACITY    = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    // position + amount reaches 126, so compares run at least 7 bits wide
    localparam int CMP_W       = (CNT_W > 7) ? CNT_W : 7;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 6;
    localparam int OUT_CNT_W   = 6;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_INSERT = 2'd1,
        K_REMOVE = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_OK   = 2'd0,
        S_FULL = 2'd1,
        S_BAD  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_REMOVE = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        CH_HOLD   = 2'd0,
        CH_APPEND = 2'd1,
        CH_INSERT = 2'd2,
        CH_SHL    = 2'd3
    } t_chain_op;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_PREV = 2'd2,
        CELL_NEXT = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
    } t_pair;

    typedef struct packed {
        t_chain_op        op;
        logic [IDX_W-1:0] idx;
        t_pair            pair;
    } t_chain_cmd;

endpackage

// File: rtl/plir_cell.sv
// One list cell: holds a pair, loads a new one or takes a neighbor's.
// Depends on plir_pkg.
module plir_cell (
    input  logic             i_clk,
    input  plir_pkg::t_cell_op i_op,
    input  plir_pkg::t_pair  i_load,
    input  plir_pkg::t_pair  i_prev,
    input  plir_pkg::t_pair  i_next,
    output plir_pkg::t_pair  o_pair
);
    import plir_pkg::*;

    t_pair r_pair;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD: r_pair <= i_load;
            CELL_PREV: r_pair <= i_prev;
            CELL_NEXT: r_pair <= i_next;
            default:   r_pair <= r_pair;
        endcase
    end

    assign o_pair = r_pair;

endmodule

// File: rtl/plir_chain.sv
// Row of CAPACITY cells; decodes the broadcast command into a per-cell op
// and reads one cell by index. Depends on plir_pkg and plir_cell.
module plir_chain (
    input  logic                         i_clk,
    input  plir_pkg::t_chain_cmd         i_cmd,
    input  logic [plir_pkg::IDX_W-1:0]   i_rd_idx,
    output plir_pkg::t_pair              o_rd_pair
);
    import plir_pkg::*;

    t_pair    w_pair [CAPACITY];
    t_cell_op w_op   [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_pair w_prev;
            t_pair w_next;

            if (gi == 0) begin : g_first
                assign w_prev = i_cmd.pair;
            end else begin : g_mid
                assign w_prev = w_pair[gi-1];
            end

            // top cell shifting left keeps its own (unused) contents
            if (gi == CAPACITY - 1) begin : g_top
                assign w_next = w_pair[gi];
            end else begin : g_low
                assign w_next = w_pair[gi+1];
            end

            always_comb begin
                w_op[gi] = CELL_HOLD;
                unique case (i_cmd.op)
                    CH_APPEND: begin
                        if (i_cmd.idx == IDX_W'(gi)) w_op[gi] = CELL_LOAD;
                    end
                    CH_INSERT: begin
                        if (i_cmd.idx == IDX_W'(gi))     w_op[gi] = CELL_LOAD;
                        else if (IDX_W'(gi) > i_cmd.idx) w_op[gi] = CELL_PREV;
                    end
                    CH_SHL: begin
                        if (IDX_W'(gi) >= i_cmd.idx) w_op[gi] = CELL_NEXT;
                    end
                    default: w_op[gi] = CELL_HOLD;
                endcase
            end

            plir_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_op[gi]),
                .i_load (i_cmd.pair),
                .i_prev (w_prev),
                .i_next (w_next),
                .o_pair (w_pair[gi])
            );
        end
    endgenerate

    assign o_rd_pair = w_pair[i_rd_idx];

endmodule

// File: rtl/pair_list_insert_remove_range_top.sv
// Pair list top: request decode, count, removal sequencer, output register.
// Append, insert, read and rejected requests give their one word in the cycle
// after acceptance; a removal of n pairs gives n words, each registered in ST_REMOVE,
// one per cycle while the sink takes them.
// Throughput: one request per cycle if the output is free; removal blocks until done.
// Reset clears the count, the state and the output valid; cell contents are not cleared.
module pair_list_insert_remove_range_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // position[5:0], amount[11:6], first_in[43:12], second_in[75:44], zero pad
    input  logic [plir_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // first_out[31:0], second_out[63:32], status[65:64], entries_now[71:66]
    output logic [plir_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // has_pair[0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import plir_pkg::*;

    t_state                r_state,   n_state;
    logic [CNT_W-1:0]      r_count,   n_count;
    logic [IDX_W-1:0]      r_rm_pos,  n_rm_pos;
    logic [CNT_W-1:0]      r_rm_left, n_rm_left;
    logic                  r_m_valid, n_m_valid;
    logic [DATA_W-1:0]     r_first,   n_first;
    logic [DATA_W-1:0]     r_second,  n_second;
    logic                  r_has,     n_has;
    t_status               r_status,  n_status;
    logic [OUT_CNT_W-1:0]  r_cnt_out, n_cnt_out;
    logic                  r_last,    n_last;

    t_kind                 w_kind;
    logic [POS_W-1:0]      w_pos;
    logic [POS_W-1:0]      w_amt;
    t_pair                 w_in_pair;
    logic [CMP_W-1:0]      w_pos_x, w_amt_x, w_sum_x, w_cnt_x;
    logic                  w_out_free;
    logic                  w_accept;
    t_chain_cmd            w_cmd;
    logic [IDX_W-1:0]      w_rd_idx;
    t_pair                 w_rd_pair;

    assign w_kind           = t_kind'(s_axis_tuser);
    assign w_pos            = s_axis_tdata[5:0];
    assign w_amt            = s_axis_tdata[11:6];
    assign w_in_pair.first  = s_axis_tdata[43:12];
    assign w_in_pair.second = s_axis_tdata[75:44];

    assign w_pos_x = CMP_W'(w_pos);
    assign w_amt_x = CMP_W'(w_amt);
    assign w_sum_x = w_pos_x + w_amt_x;
    assign w_cnt_x = CMP_W'(r_count);

    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_rd_idx      = (r_state == ST_REMOVE) ? r_rm_pos : w_pos[IDX_W-1:0];

    plir_chain u_chain (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_rd_idx  (w_rd_idx),
        .o_rd_pair (w_rd_pair)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rm_pos   = r_rm_pos;
        n_rm_left  = r_rm_left;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_first    = r_first;
        n_second   = r_second;
        n_has      = r_has;
        n_status   = r_status;
        n_cnt_out  = r_cnt_out;
        n_last     = r_last;
        w_cmd.op   = CH_HOLD;
        w_cmd.idx  = w_pos[IDX_W-1:0];
        w_cmd.pair = w_in_pair;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // default word: no pair, last of its request
                    n_m_valid = 1'b1;
                    n_first   = '0;
                    n_second  = '0;
                    n_has     = 1'b0;
                    n_status  = S_OK;
                    n_last    = 1'b1;
                    unique case (w_kind)
                        K_APPEND: begin
                            if (w_cnt_x >= CMP_W'(CAPACITY)) begin
                                n_status = S_FULL;
                            end else begin
                                w_cmd.op  = CH_APPEND;
                                w_cmd.idx = r_count[IDX_W-1:0];
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        K_INSERT: begin
                            if (w_pos_x >= w_cnt_x) begin
                                n_status = S_BAD;
                            end else if (w_cnt_x >= CMP_W'(CAPACITY)) begin
                                n_status = S_FULL;
                            end else begin
                                w_cmd.op = CH_INSERT;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        K_REMOVE: begin
                            if (w_amt_x >= w_cnt_x || w_sum_x >= w_cnt_x) begin
                                n_status = S_BAD;
                            end else if (w_amt != '0) begin
                                // count drops now; words follow from ST_REMOVE
                                n_m_valid = 1'b0;
                                n_count   = r_count - CNT_W'(w_amt);
                                n_rm_pos  = w_pos[IDX_W-1:0];
                                n_rm_left = CNT_W'(w_amt);
                                n_state   = ST_REMOVE;
                            end
                        end
                        K_READ: begin
                            if (w_pos_x >= w_cnt_x) begin
                                n_status = S_BAD;
                            end else begin
                                n_first  = w_rd_pair.first;
                                n_second = w_rd_pair.second;
                                n_has    = 1'b1;
                            end
                        end
                        default: n_status = S_BAD;
                    endcase
                    n_cnt_out = OUT_CNT_W'(n_count);
                end
            end
            ST_REMOVE: begin
                if (w_out_free) begin
                    // emit the cell at the start, then close the gap by one
                    n_m_valid = 1'b1;
                    n_first   = w_rd_pair.first;
                    n_second  = w_rd_pair.second;
                    n_has     = 1'b1;
                    n_status  = S_OK;
                    n_cnt_out = OUT_CNT_W'(r_count);
                    n_last    = (r_rm_left == CNT_W'(1));
                    w_cmd.op  = CH_SHL;
                    w_cmd.idx = r_rm_pos;
                    n_rm_left = r_rm_left - CNT_W'(1);
                    if (r_rm_left == CNT_W'(1)) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rm_left <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rm_left <= n_rm_left;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rm_pos  <= n_rm_pos;
        r_first   <= n_first;
        r_second  <= n_second;
        r_has     <= n_has;
        r_status  <= n_status;
        r_cnt_out <= n_cnt_out;
        r_last    <= n_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_cnt_out, r_status, r_second, r_first};
    assign m_axis_tuser  = r_has;
    assign m_axis_tlast  = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(CAPACITY))
        else $error("entry count above capacity");

    a_remove_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REMOVE) |-> (r_rm_left != '0))
        else $error("removal running with nothing left");

    a_remove_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REMOVE && w_out_free && r_rm_left == CNT_W'(1))
        |=> (m_axis_tvalid && m_axis_tlast && m_axis_tuser && r_state == ST_IDLE))
        else $error("final removed word not marked last");

    a_pair_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_status == S_OK))
        else $error("word with a pair carries an error status");

endmodule
